// File: rtl/hltp_pkg.sv
// shared types and constants for the linear-probing hash table
package hltp_pkg;

    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 32;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } t_mark;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } t_state;

    // write request into the slot memories
    typedef struct packed {
        logic               mark_we;
        t_mark              mark;
        logic               data_we;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot_wr;

endpackage

// File: rtl/hltp_home.sv
// home slot unit: key modulo table size by reciprocal multiplication
module hltp_home #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [hltp_pkg::KEY_W-1:0]            i_key,
    output logic                                  o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]         o_home
);
    import hltp_pkg::*;

    localparam int ADDR_W  = $clog2(TABLE_SIZE);
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int SHIFT   = KEY_W + ADDR_W;
    // reciprocal rounded up, exact quotient for every key below 2**KEY_W
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_FULL);
    localparam logic [ADDR_W-1:0]  MOD_LO = ADDR_W'(TABLE_SIZE);

    logic                r_load;
    logic                r_mult;
    logic                r_done;
    logic [KEY_W-1:0]    r_key;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_rem;
    logic [ADDR_W-1:0]   quot_lo;
    logic [ADDR_W-1:0]   n_rem;

    // the remainder is below TABLE_SIZE, so low quotient bits suffice
    assign quot_lo = r_prod[SHIFT +: ADDR_W];
    assign n_rem   = r_key[ADDR_W-1:0] - quot_lo * MOD_LO;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_mult <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_load <= i_start;
            r_mult <= r_load;
            r_done <= r_mult;
        end
    end

    // key capture, 31 by 32 bit product, remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_load) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(RECIP);
        end
        if (r_mult) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

// File: rtl/hltp_slots.sv
// slot memories: mark array and key/value array, registered reads
module hltp_slots #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                                  i_clk,
    input  logic [$clog2(TABLE_SIZE)-1:0]         i_rd_addr,
    input  logic [$clog2(TABLE_SIZE)-1:0]         i_wr_addr,
    input  hltp_pkg::t_slot_wr                    i_wr,
    output hltp_pkg::t_mark                       o_rd_mark,
    output logic [hltp_pkg::KEY_W-1:0]            o_rd_key,
    output logic [hltp_pkg::VALUE_W-1:0]          o_rd_value
);
    import hltp_pkg::*;

    localparam int DATA_W = KEY_W + VALUE_W;

    t_mark             mark_mem [TABLE_SIZE];
    logic [DATA_W-1:0] data_mem [TABLE_SIZE];
    logic [DATA_W-1:0] r_rd_data;
    t_mark             r_rd_mark;

    // mark memory
    always_ff @(posedge i_clk) begin
        if (i_wr.mark_we) begin
            mark_mem[i_wr_addr] <= i_wr.mark;
        end
        r_rd_mark <= mark_mem[i_rd_addr];
    end

    // key and value memory
    always_ff @(posedge i_clk) begin
        if (i_wr.data_we) begin
            data_mem[i_wr_addr] <= {i_wr.key, i_wr.value};
        end
        r_rd_data <= data_mem[i_rd_addr];
    end

    assign o_rd_mark  = r_rd_mark;
    assign o_rd_key   = r_rd_data[DATA_W-1:VALUE_W];
    assign o_rd_value = r_rd_data[VALUE_W-1:0];

endmodule

// File: rtl/hash_table_linear_probe.sv
// Open-addressing key/value table with linear probing and deleted-slot marks.
// One transaction is handled at a time: the home slot (key mod TABLE_SIZE) is
// found by a reciprocal multiply, then the slot memory is read one slot per
// cycle from home, wrapping, with one read kept in flight ahead of the slot
// being checked, until the key, an empty slot or a full sweep ends the probe;
// a probe checks from 1 to TABLE_SIZE slots. The finish state then writes back
// and loads the result register, waiting while a stalled earlier result holds
// the output register, and the next transaction can be accepted once the
// control is back in idle. The single read port of the slot memory sets the
// probe rate. After reset a clearing pass marks every slot empty, with input
// stalled.
// A finished result waits in its output register while the next item is taken.
module hash_table_linear_probe #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [hltp_pkg::MODE_W-1:0]           i_mode,
    input  logic [hltp_pkg::KEY_W-1:0]            i_key,
    input  logic signed [hltp_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [hltp_pkg::STATUS_W-1:0]         o_status,
    output logic signed [hltp_pkg::VALUE_W-1:0]   o_read_value
);
    import hltp_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

    t_state             r_state, n_state;
    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [ADDR_W-1:0]  r_issue, n_issue;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic               r_have, n_have;
    logic [ADDR_W-1:0]  r_count, n_count;
    logic               r_gone_ok, n_gone_ok;
    logic [ADDR_W-1:0]  r_gone_pos, n_gone_pos;
    logic               r_found, n_found;
    logic [ADDR_W-1:0]  r_target, n_target;
    logic               r_target_ok, n_target_ok;
    logic [VALUE_W-1:0] r_hit_value, n_hit_value;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_read_value, n_read_value;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;

    logic               in_accept;
    logic               hash_done;
    logic [ADDR_W-1:0]  hash_home;
    t_mark              rd_mark;
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    t_slot_wr           wr;
    logic [ADDR_W-1:0]  wr_addr;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // home slot
    hltp_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_key   (i_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    // slot storage
    hltp_slots #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rd_addr  (r_issue),
        .i_wr_addr  (wr_addr),
        .i_wr       (wr),
        .o_rd_mark  (rd_mark),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

    assign wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_target;

    // next state, probe evaluation and write-back
    always_comb begin
        logic ended;
        ended        = 1'b0;
        n_state      = r_state;
        n_issue      = r_issue;
        n_pos        = r_pos;
        n_have       = r_have;
        n_count      = r_count;
        n_gone_ok    = r_gone_ok;
        n_gone_pos   = r_gone_pos;
        n_found      = r_found;
        n_target     = r_target;
        n_target_ok  = r_target_ok;
        n_hit_value  = r_hit_value;
        n_status     = r_status;
        n_read_value = r_read_value;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid && i_out_stall;
        wr           = '0;
        wr.key       = r_key;
        wr.value     = r_value;

        unique case (r_state)
            ST_CLEAR: begin
                wr.mark_we = 1'b1;
                wr.mark    = MARK_EMPTY;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    n_issue   = hash_home;
                    n_have    = 1'b0;
                    n_count   = '0;
                    n_gone_ok = 1'b0;
                    n_state   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // keep one read in flight ahead of the slot being checked
                n_issue = (r_issue == LAST) ? '0 : r_issue + 1'b1;
                n_pos   = r_issue;
                n_have  = 1'b1;
                if (r_have) begin
                    n_count = r_count + 1'b1;
                    unique case (rd_mark)
                        MARK_EMPTY: begin
                            ended       = 1'b1;
                            n_found     = 1'b0;
                            n_target    = r_gone_ok ? r_gone_pos : r_pos;
                            n_target_ok = 1'b1;
                        end
                        MARK_USED: begin
                            if (rd_key == r_key) begin
                                ended       = 1'b1;
                                n_found     = 1'b1;
                                n_target    = r_pos;
                                n_target_ok = 1'b1;
                                n_hit_value = rd_value;
                            end
                        end
                        MARK_GONE: begin
                            if (!r_gone_ok) begin
                                n_gone_ok  = 1'b1;
                                n_gone_pos = r_pos;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // full sweep without a hit
                    if (!ended && r_count == LAST) begin
                        ended       = 1'b1;
                        n_found     = 1'b0;
                        n_target    = n_gone_pos;
                        n_target_ok = n_gone_ok;
                    end
                    if (ended) begin
                        n_have  = 1'b0;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_read_value = '0;
                    n_status     = STATUS_MISS;
                    n_state      = ST_IDLE;
                    unique case (r_mode)
                        MODE_LOOKUP: begin
                            if (r_found) begin
                                n_status     = STATUS_OK;
                                n_read_value = r_hit_value;
                            end
                        end
                        MODE_INSERT: begin
                            if (r_found) begin
                                wr.data_we = 1'b1;
                                n_status   = STATUS_OK;
                            end else if (r_target_ok) begin
                                wr.mark_we = 1'b1;
                                wr.mark    = MARK_USED;
                                wr.data_we = 1'b1;
                                n_status   = STATUS_OK;
                            end else begin
                                n_status   = STATUS_FULL;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_found) begin
                                wr.mark_we = 1'b1;
                                wr.mark    = MARK_GONE;
                                n_status   = STATUS_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // transaction payload and probe bookkeeping
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_issue      <= n_issue;
        r_pos        <= n_pos;
        r_count      <= n_count;
        r_gone_ok    <= n_gone_ok;
        r_gone_pos   <= n_gone_pos;
        r_found      <= n_found;
        r_target     <= n_target;
        r_target_ok  <= n_target_ok;
        r_hit_value  <= n_hit_value;
        r_status     <= n_status;
        r_read_value <= n_read_value;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

`ifndef SYNTHESIS
    // the slot memories are never written while a probe is running
    a_no_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HASH || r_state == ST_PROBE) |-> (!wr.mark_we && !wr.data_we))
        else $error("slot memory written during probe");

    // the remainder unit finishes only while the control waits for it
    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == ST_HASH))
        else $error("home slot ready outside hash state");

    // a finished transaction with a free output register becomes a result
    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && (!r_out_valid || !i_out_stall))
        |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished transaction did not reach the output");

    // a result never appears without the control having finished
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == ST_FINISH))
        else $error("result without finished transaction");
`endif

endmodule
